>>> design/sled_pkg.sv
// sled_pkg: shared types and codes for the string literal escape decoder.
// Depends on nothing; imported by every module of the decoder.
package sled_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NEWLINE  = 2'd1;
    localparam logic [1:0] ERR_ESCAPE   = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED = 2'd3;

    // Input word: one source byte with its marks
    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_mark;
        logic       end_mark;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [1:0] error_code;
        logic       last;
    } out_word_t;

    // Queue entry: one or two results caused by one input word
    typedef struct packed {
        logic      two;
        out_word_t first;
        out_word_t second;
    } sled_entry_t;

endpackage

>>> design/sled_front.sv
// sled_front: literal state machine; classifies each input word and queues its results.
// Depends on sled_pkg.
module sled_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sled_pkg::in_word_t item,
    input  logic               q_full,
    output logic               q_wr,
    output sled_pkg::sled_entry_t q_entry
);
    import sled_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE, M_BODY, M_ESC, M_HEX1, M_HEX2, M_OCT1, M_OCT2
    } mode_t;

    // Character codes
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6e;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_V  = 8'h76;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;

    function automatic out_word_t mk(input logic [1:0] k, input logic [7:0] v,
                                     input logic [1:0] e);
        out_word_t w;
        w.kind       = k;
        w.value      = v;
        w.error_code = e;
        w.last       = 1'b0;
        return w;
    endfunction

    // Hex digit value; 16 flags a non-hex byte
    function automatic logic [4:0] hexv(input logic [7:0] c);
        logic [7:0] f;
        f = c;
        if (c inside {[CH_UP_A:CH_UP_Z]})
            f = c + 8'd32;
        if (f inside {[CH_0:CH_9]})
            return 5'(f - CH_0);
        else if (f inside {[CH_LO_A:CH_LO_F]})
            return 5'(f - CH_LO_A + 8'd10);
        else
            return 5'd16;
    endfunction

    mode_t      mode_reg, mode_next;
    logic       dq_reg, dq_next;
    logic [7:0] acc_reg, acc_next;

    logic       accept;
    logic [7:0] b;
    logic [7:0] quote;
    logic       is_oct;
    logic [7:0] oct_acc;
    logic [4:0] hi, lo;

    // Ordinary literal byte handling, shared by body and short-octal paths
    logic       body_has;
    out_word_t  body_word;
    mode_t      body_mode;

    logic       simple;
    logic [7:0] simple_val;

    logic       has0, has1;
    out_word_t  w0, w1;

    assign accept  = push && !q_full;
    assign b       = item.text_byte;
    assign quote   = dq_reg ? CH_DQ : CH_SQ;
    assign is_oct  = b inside {[CH_0:CH_7]};
    assign oct_acc = {acc_reg[4:0], b[2:0]};
    assign hi      = hexv(acc_reg);
    assign lo      = hexv(b);

    // Body byte classification
    always_comb
    begin
        body_has  = 1'b1;
        body_mode = M_BODY;
        body_word = mk(KIND_DATA, b, ERR_NONE);
        if (b == quote)
        begin
            body_word = mk(KIND_CLOSED, 8'd0, ERR_NONE);
            body_mode = M_IDLE;
        end
        else if (b == CH_LF && !dq_reg)
        begin
            body_word = mk(KIND_ERROR, 8'd0, ERR_NEWLINE);
            body_mode = M_IDLE;
        end
        else if (b == CH_BSL)
        begin
            body_has  = 1'b0;
            body_mode = M_ESC;
        end
    end

    // Simple escape lookup
    always_comb
    begin
        simple     = 1'b1;
        simple_val = b;
        case (b)
            CH_SQ, CH_DQ, CH_BSL: simple_val = b;
            CH_LO_A: simple_val = CH_BEL;
            CH_LO_B: simple_val = CH_BS;
            CH_LO_F: simple_val = CH_FF;
            CH_LO_N: simple_val = CH_LF;
            CH_LO_R: simple_val = CH_CR;
            CH_LO_T: simple_val = CH_TAB;
            CH_LO_V: simple_val = CH_VT;
            default: simple = 1'b0;
        endcase
    end

    // Next state and results of the current word
    always_comb
    begin
        mode_next = mode_reg;
        dq_next   = dq_reg;
        acc_next  = acc_reg;
        has0      = 1'b0;
        has1      = 1'b0;
        w0        = mk(KIND_DATA, 8'd0, ERR_NONE);
        w1        = mk(KIND_DATA, 8'd0, ERR_NONE);
        if (item.end_mark)
        begin
            case (mode_reg)
                M_BODY, M_ESC:
                begin
                    has0 = 1'b1;
                    w0   = mk(KIND_ERROR, 8'd0, ERR_UNCLOSED);
                end
                M_HEX1, M_HEX2:
                begin
                    has0 = 1'b1;
                    w0   = mk(KIND_ERROR, 8'd0, ERR_ESCAPE);
                end
                M_OCT1, M_OCT2:
                begin
                    has0 = 1'b1;
                    has1 = 1'b1;
                    w0   = mk(KIND_DATA, acc_reg, ERR_NONE);
                    w1   = mk(KIND_ERROR, 8'd0, ERR_UNCLOSED);
                end
                default: ;
            endcase
            mode_next = M_IDLE;
            acc_next  = 8'd0;
        end
        else if (item.start_mark)
        begin
            dq_next   = (b == CH_DQ);
            mode_next = M_BODY;
            acc_next  = 8'd0;
        end
        else
        begin
            case (mode_reg)
                M_BODY:
                begin
                    has0      = body_has;
                    w0        = body_word;
                    mode_next = body_mode;
                end
                M_ESC:
                begin
                    if (simple)
                    begin
                        has0      = 1'b1;
                        w0        = mk(KIND_DATA, simple_val, ERR_NONE);
                        mode_next = M_BODY;
                    end
                    else if (b == CH_LO_X)
                        mode_next = M_HEX1;
                    else if (is_oct)
                    begin
                        acc_next  = {5'd0, b[2:0]};
                        mode_next = M_OCT1;
                    end
                    else
                    begin
                        has0      = 1'b1;
                        w0        = mk(KIND_ERROR, 8'd0, ERR_ESCAPE);
                        mode_next = M_IDLE;
                    end
                end
                M_HEX1:
                begin
                    if (b == quote)
                    begin
                        has0      = 1'b1;
                        w0        = mk(KIND_ERROR, 8'd0, ERR_ESCAPE);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        acc_next  = b;
                        mode_next = M_HEX2;
                    end
                end
                M_HEX2:
                begin
                    has0 = 1'b1;
                    if (b == quote || hi[4] || lo[4])
                    begin
                        w0        = mk(KIND_ERROR, 8'd0, ERR_ESCAPE);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        w0        = mk(KIND_DATA, {hi[3:0], lo[3:0]}, ERR_NONE);
                        mode_next = M_BODY;
                    end
                end
                M_OCT1, M_OCT2:
                begin
                    if (is_oct)
                    begin
                        acc_next = oct_acc;
                        if (mode_reg == M_OCT1)
                            mode_next = M_OCT2;
                        else
                        begin
                            has0      = 1'b1;
                            w0        = mk(KIND_DATA, oct_acc, ERR_NONE);
                            mode_next = M_BODY;
                        end
                    end
                    else
                    begin
                        // short octal escape: flush value, then treat byte as body
                        has0      = 1'b1;
                        w0        = mk(KIND_DATA, acc_reg, ERR_NONE);
                        has1      = body_has;
                        w1        = body_word;
                        mode_next = body_mode;
                    end
                end
                default: ;
            endcase
        end
        if (has1)
            w1.last = 1'b1;
        else
            w0.last = 1'b1;
    end

    assign q_wr           = accept && has0;
    assign q_entry.two    = has1;
    assign q_entry.first  = w0;
    assign q_entry.second = w1;

    // Literal state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            dq_reg   <= 1'b0;
            acc_reg  <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            dq_reg   <= dq_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

>>> design/sled_fifo.sv
// sled_fifo: short queue of result entries between the front and back parts.
// Depends on sled_pkg.
module sled_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  sled_pkg::sled_entry_t wr_entry,
    output logic                  full,
    input  logic                  rd_en,
    output sled_pkg::sled_entry_t rd_entry,
    output logic                  empty
);
    import sled_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

    sled_entry_t   mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          do_wr, do_rd;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = mem[rp_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == LAST_PTR) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == LAST_PTR) ? '0 : rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> design/sled_back.sv
// sled_back: splits queued entries into single result words and holds the output register.
// Depends on sled_pkg.
module sled_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  sled_pkg::sled_entry_t q_entry,
    output logic                  q_rd,
    output sled_pkg::out_word_t   result,
    output logic                  empty,
    input  logic                  pop
);
    import sled_pkg::*;

    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic      hold_valid_reg;
    out_word_t hold_word_reg;
    logic      take;

    // Output slot frees when empty or being popped
    assign take   = !out_valid_reg || pop;
    assign q_rd   = take && !hold_valid_reg && !q_empty;
    assign result = out_word_reg;
    assign empty  = !out_valid_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (hold_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= q_entry.two;
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (hold_valid_reg)
                out_word_reg <= hold_word_reg;
            else if (!q_empty)
            begin
                out_word_reg  <= q_entry.first;
                hold_word_reg <= q_entry.second;
            end
        end
    end

endmodule

>>> design/string_literal_escape_decoder_unit.sv
// string_literal_escape_decoder_unit: top level of the string literal escape decoder.
// Depends on sled_pkg, sled_front, sled_fifo, sled_back.
//
//   channel | handshake        | word
//   --------+------------------+-------------------------------------------
//   input   | push / full      | item   : text_byte, start_mark, end_mark
//   result  | pop / empty      | result : kind, value, error_code, last
//
// One input word is taken per cycle while the queue has room; its state update
// is a single registered step of the front state machine.
// Results leave one per cycle from the output register while they are popped; a word
// with two results takes one DEPTH-entry queue slot; the second waits in sled_back.
// A result passes the queue and then the output register before reaching the ports.
// Reset is asynchronous, active low; no clearing pass is needed.
module string_literal_escape_decoder_unit #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sled_pkg::in_word_t  item,
    output logic                empty,
    input  logic                pop,
    output sled_pkg::out_word_t result
);
    import sled_pkg::*;

    logic        q_wr, q_rd, q_full, q_empty;
    sled_entry_t q_wr_entry, q_rd_entry;

    assign full = q_full;

    sled_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_entry (q_wr_entry)
    );

    sled_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .rd_en    (q_rd),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    sled_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_entry (q_rd_entry),
        .q_rd    (q_rd),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

>>> design/sled_checker.sv
// sled_checker: port-level checks on the decoder's result channel, bound to the top level.
// Depends on sled_pkg and string_literal_escape_decoder_unit.
module sled_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input sled_pkg::out_word_t result
);
    import sled_pkg::*;

    // A waiting result word is not withdrawn or changed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result word changed while stalled");

    // Only data words carry a value
    a_value: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.kind != KIND_DATA |-> result.value == 8'd0)
        else $error("nonzero value on a non-data word");

    // Error code present exactly on error words
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.kind == KIND_ERROR) == (result.error_code != ERR_NONE)))
        else $error("error code does not match kind");

    // Close and error words always end their input word's results
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.kind != KIND_DATA |-> result.last)
        else $error("close or error word without last");

endmodule

bind string_literal_escape_decoder_unit sled_checker u_sled_checker (.*);
